/* rtl/fancoil_fan_speed_stager_unit_defines.svh */
// ----------------------------------------------------------------------------
// Fan speed stager assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef FANCOIL_FAN_SPEED_STAGER_UNIT_DEFINES_SVH
`define FANCOIL_FAN_SPEED_STAGER_UNIT_DEFINES_SVH

// same-cycle implication
`define FCFS_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define FCFS_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

/* rtl/fcfs_pkg.sv */
// ----------------------------------------------------------------------------
// Fan speed stager package
// Widths, reset values, register indexes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam int unsigned TEMP_W       = 14;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned DIVIDEND_W   = 15;
    localparam int unsigned DIVISOR_W    = 8;
    localparam int unsigned DIV_CNT_W    = $clog2(DIVIDEND_W + 1);

    localparam logic [7:0]  BLDC_START_MARGIN = 8'd10;
    localparam logic [6:0]  PCT_SCALE         = 7'd100;
    localparam logic [3:0]  SETPOINT_SCALE    = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_KIND      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BAND        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_BAND     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_FOLLOWS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON_MS       = 3'd5;

    localparam logic        RST_MOTOR_KIND      = 1'b0;
    localparam logic [7:0]  RST_LOW_BAND        = 8'd5;
    localparam logic [7:0]  RST_MIDDLE_BAND     = 8'd10;
    localparam logic [7:0]  RST_SPEED_THRESHOLD = 8'd3;
    localparam logic        RST_VALVE_FOLLOWS   = 1'b0;
    localparam logic [15:0] RST_MIN_ON_MS       = 16'd3000;

    localparam logic [1:0]  PHASE_IDLE = 2'd0;
    localparam logic [1:0]  PHASE_OFF  = 2'd1;
    localparam logic [1:0]  PHASE_ON   = 2'd2;

    localparam logic [7:0]  SPEED_OFF  = 8'd0;
    localparam logic [7:0]  SPEED_ONE  = 8'd1;
    localparam logic [7:0]  SPEED_TWO  = 8'd2;
    localparam logic [7:0]  SPEED_THREE = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RULE,
        ST_DIV,
        ST_STEP,
        ST_APPLY
    } fcfs_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fcfs_div_status_t;

endpackage

/* rtl/fancoil_fan_speed_stager_unit.sv */
// ----------------------------------------------------------------------------
// Fan-coil fan speed stager
// Picks and stages the fan speed and valve request for one control pass.
// ----------------------------------------------------------------------------
// One word in gives one word out. A stepped-motor pass, a BLDC pass without a
// loop tick and a BLDC pass that needs no target go from the rules state
// straight to the apply state. A BLDC pass whose target is the upper band goes
// through the rules, the duty step and apply. A BLDC pass that needs the
// proportional target goes through the rules, the fifteen-step restoring
// divider, the hand-over of the quotient, the duty step and apply. The input
// is stalled from acceptance until the result is written to the output
// register, so a new word is taken only once the previous pass is finished.
// A finished result waits in the output register and the next word is taken
// meanwhile; that word's result waits until the register is free.
module fancoil_fan_speed_stager_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fcfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fcfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [11:0]                         room_temp,
    input  logic [5:0]                          setpoint,
    input  logic                                regulator_on,
    input  logic                                heating,
    input  logic                                loop_tick,
    input  logic [31:0]                         now_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          fan_demand,
    output logic [7:0]                          fan_drive,
    output logic                                valve_request
);

    fcfs_pkg::fcfs_state_t               state_reg, state_next;

    logic                                motor_kind_reg;
    logic [7:0]                          low_band_reg;
    logic [7:0]                          middle_band_reg;
    logic [7:0]                          speed_threshold_reg;
    logic                                valve_follows_reg;
    logic [15:0]                         min_on_ms_reg;

    logic [7:0]                          demand_speed_reg, demand_speed_next;
    logic [7:0]                          applied_speed_reg, applied_speed_next;
    logic [1:0]                          switch_phase_reg, switch_phase_next;
    logic [31:0]                         hold_start_reg, hold_start_next;
    logic                                valve_flag_reg, valve_flag_next;
    logic [7:0]                          drive_value_reg, drive_value_next;

    logic [11:0]                         room_temp_reg;
    logic [5:0]                          setpoint_reg;
    logic                                regulator_on_reg;
    logic                                heating_reg;
    logic                                loop_tick_reg;
    logic [31:0]                         now_ms_reg;

    logic [fcfs_pkg::DIVIDEND_W-1:0]     target_reg, target_next;
    logic                                out_valid_reg, out_valid_next;
    logic [7:0]                          out_demand_reg, out_demand_next;
    logic [7:0]                          out_drive_reg, out_drive_next;
    logic                                out_valve_reg, out_valve_next;

    logic signed [fcfs_pkg::TEMP_W-1:0]  t_s, sp_s, lo_s, mid_s, th_s, err_s, margin_s;
    logic                                div_start;
    logic [fcfs_pkg::DIVIDEND_W-1:0]     div_dividend;
    logic [fcfs_pkg::DIVISOR_W-1:0]      div_divisor;
    fcfs_pkg::fcfs_div_status_t          div_status;
    logic [fcfs_pkg::DIVIDEND_W-1:0]     div_quotient;
    logic [8:0]                          step_val;
    logic [31:0]                         elapsed;
    logic                                change_ok;
    logic                                in_accept;

    fcfs_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != fcfs_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_kind_reg      <= fcfs_pkg::RST_MOTOR_KIND;
            low_band_reg        <= fcfs_pkg::RST_LOW_BAND;
            middle_band_reg     <= fcfs_pkg::RST_MIDDLE_BAND;
            speed_threshold_reg <= fcfs_pkg::RST_SPEED_THRESHOLD;
            valve_follows_reg   <= fcfs_pkg::RST_VALVE_FOLLOWS;
            min_on_ms_reg       <= fcfs_pkg::RST_MIN_ON_MS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fcfs_pkg::CFG_MOTOR_KIND:      motor_kind_reg      <= cfg_data[0];
                fcfs_pkg::CFG_LOW_BAND:        low_band_reg        <= cfg_data[7:0];
                fcfs_pkg::CFG_MIDDLE_BAND:     middle_band_reg     <= cfg_data[7:0];
                fcfs_pkg::CFG_SPEED_THRESHOLD: speed_threshold_reg <= cfg_data[7:0];
                fcfs_pkg::CFG_VALVE_FOLLOWS:   valve_follows_reg   <= cfg_data[0];
                fcfs_pkg::CFG_MIN_ON_MS:       min_on_ms_reg       <= cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= fcfs_pkg::ST_IDLE;
            demand_speed_reg  <= '0;
            applied_speed_reg <= '0;
            switch_phase_reg  <= fcfs_pkg::PHASE_IDLE;
            hold_start_reg    <= '0;
            valve_flag_reg    <= 1'b0;
            drive_value_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            demand_speed_reg  <= demand_speed_next;
            applied_speed_reg <= applied_speed_next;
            switch_phase_reg  <= switch_phase_next;
            hold_start_reg    <= hold_start_next;
            valve_flag_reg    <= valve_flag_next;
            drive_value_reg   <= drive_value_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            room_temp_reg    <= room_temp;
            setpoint_reg     <= setpoint;
            regulator_on_reg <= regulator_on;
            heating_reg      <= heating;
            loop_tick_reg    <= loop_tick;
            now_ms_reg       <= now_ms;
        end
        target_reg     <= target_next;
        out_demand_reg <= out_demand_next;
        out_drive_reg  <= out_drive_next;
        out_valve_reg  <= out_valve_next;
    end

    always_comb
    begin
        t_s      = $signed({2'b00, room_temp_reg});
        sp_s     = $signed(fcfs_pkg::TEMP_W'(setpoint_reg * fcfs_pkg::SETPOINT_SCALE));
        lo_s     = $signed({6'b000000, low_band_reg});
        mid_s    = $signed({6'b000000, middle_band_reg});
        th_s     = $signed({6'b000000, speed_threshold_reg});
        margin_s = $signed({6'b000000, fcfs_pkg::BLDC_START_MARGIN});
        err_s    = heating_reg ? (sp_s - t_s) : (t_s - sp_s);
        elapsed  = now_ms_reg - hold_start_reg;
        change_ok = (demand_speed_reg != applied_speed_reg) &&
                    (elapsed >= {16'h0000, min_on_ms_reg});

        div_start    = 1'b0;
        div_dividend = fcfs_pkg::DIVIDEND_W'(err_s[7:0] * fcfs_pkg::PCT_SCALE);
        div_divisor  = (speed_threshold_reg == 8'd0) ? 8'd1 : speed_threshold_reg;
        step_val     = {1'b0, demand_speed_reg};

        state_next         = state_reg;
        demand_speed_next  = demand_speed_reg;
        applied_speed_next = applied_speed_reg;
        switch_phase_next  = switch_phase_reg;
        hold_start_next    = hold_start_reg;
        valve_flag_next    = valve_flag_reg;
        drive_value_next   = drive_value_reg;
        target_next        = target_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_demand_next    = out_demand_reg;
        out_drive_next     = out_drive_reg;
        out_valve_next     = out_valve_reg;

        case (state_reg)
            fcfs_pkg::ST_IDLE:
            begin
                if (in_accept)
                    state_next = fcfs_pkg::ST_RULE;
            end
            fcfs_pkg::ST_RULE:
            begin
                state_next = fcfs_pkg::ST_APPLY;
                if (!regulator_on_reg)
                begin
                    switch_phase_next  = fcfs_pkg::PHASE_IDLE;
                    demand_speed_next  = fcfs_pkg::SPEED_OFF;
                    applied_speed_next = fcfs_pkg::SPEED_OFF;
                    drive_value_next   = fcfs_pkg::SPEED_OFF;
                    valve_flag_next    = 1'b0;
                end
                else if (motor_kind_reg)
                begin
                    if (loop_tick_reg)
                    begin
                        if ((demand_speed_reg == fcfs_pkg::SPEED_OFF) && (err_s > margin_s))
                            demand_speed_next = fcfs_pkg::SPEED_ONE;
                        else if (err_s <= 0)
                            demand_speed_next = fcfs_pkg::SPEED_OFF;
                        else if (demand_speed_reg != fcfs_pkg::SPEED_OFF)
                        begin
                            if (err_s > th_s)
                            begin
                                target_next = fcfs_pkg::DIVIDEND_W'(middle_band_reg);
                                state_next  = fcfs_pkg::ST_STEP;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = fcfs_pkg::ST_DIV;
                            end
                        end
                    end
                end
                else if (heating_reg)
                begin
                    case (demand_speed_reg)
                        fcfs_pkg::SPEED_OFF:
                            if (t_s < sp_s - lo_s)
                                demand_speed_next = fcfs_pkg::SPEED_ONE;
                        fcfs_pkg::SPEED_ONE:
                            if (t_s < sp_s - mid_s)
                                demand_speed_next = fcfs_pkg::SPEED_TWO;
                            else if (t_s >= sp_s)
                                demand_speed_next = fcfs_pkg::SPEED_OFF;
                        fcfs_pkg::SPEED_TWO:
                            if (t_s < sp_s - mid_s - lo_s)
                                demand_speed_next = fcfs_pkg::SPEED_THREE;
                            else if (t_s >= sp_s - mid_s + th_s)
                                demand_speed_next = fcfs_pkg::SPEED_ONE;
                        fcfs_pkg::SPEED_THREE:
                            if (t_s >= sp_s - mid_s - lo_s + th_s)
                                demand_speed_next = fcfs_pkg::SPEED_TWO;
                        default: ;
                    endcase
                end
                else
                begin
                    case (demand_speed_reg)
                        fcfs_pkg::SPEED_OFF:
                            if (t_s > sp_s + lo_s)
                                demand_speed_next = fcfs_pkg::SPEED_ONE;
                        fcfs_pkg::SPEED_ONE:
                            if (t_s > sp_s + mid_s)
                                demand_speed_next = fcfs_pkg::SPEED_TWO;
                            else if (t_s <= sp_s)
                                demand_speed_next = fcfs_pkg::SPEED_OFF;
                            else if ((t_s <= sp_s + th_s) && !valve_follows_reg)
                                valve_flag_next = 1'b0;
                        fcfs_pkg::SPEED_TWO:
                            if (t_s > sp_s + mid_s + lo_s)
                                demand_speed_next = fcfs_pkg::SPEED_THREE;
                            else if (t_s <= sp_s + mid_s - th_s)
                                demand_speed_next = fcfs_pkg::SPEED_ONE;
                        fcfs_pkg::SPEED_THREE:
                            if (t_s <= sp_s + mid_s + lo_s - th_s)
                                demand_speed_next = fcfs_pkg::SPEED_TWO;
                        default: ;
                    endcase
                end
            end
            fcfs_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    target_next = div_quotient;
                    state_next  = fcfs_pkg::ST_STEP;
                end
            end
            fcfs_pkg::ST_STEP:
            begin
                if (fcfs_pkg::DIVIDEND_W'(demand_speed_reg) < target_reg)
                    step_val = step_val + 9'd1;
                else if (fcfs_pkg::DIVIDEND_W'(demand_speed_reg) > target_reg)
                    step_val = step_val - 9'd1;
                if (step_val > {1'b0, middle_band_reg})
                    demand_speed_next = middle_band_reg;
                else if (step_val < {1'b0, low_band_reg})
                    demand_speed_next = low_band_reg;
                else
                    demand_speed_next = step_val[7:0];
                state_next = fcfs_pkg::ST_APPLY;
            end
            fcfs_pkg::ST_APPLY:
            begin
                if (!out_valid_reg)
                begin
                    if (change_ok)
                    begin
                        if (motor_kind_reg)
                            drive_value_next = demand_speed_reg;
                        if (switch_phase_reg != fcfs_pkg::PHASE_OFF)
                        begin
                            if (!motor_kind_reg)
                                drive_value_next = fcfs_pkg::SPEED_OFF;
                            if (applied_speed_reg != fcfs_pkg::SPEED_OFF)
                                hold_start_next = now_ms_reg;
                            switch_phase_next = fcfs_pkg::PHASE_OFF;
                        end
                        else
                        begin
                            if (!motor_kind_reg)
                                drive_value_next =
                                    ((demand_speed_reg >= fcfs_pkg::SPEED_ONE) &&
                                     (demand_speed_reg <= fcfs_pkg::SPEED_THREE)) ?
                                    demand_speed_reg : fcfs_pkg::SPEED_OFF;
                            if (demand_speed_reg != fcfs_pkg::SPEED_OFF)
                            begin
                                valve_flag_next = 1'b1;
                                hold_start_next = now_ms_reg;
                            end
                            else if (valve_follows_reg || !heating_reg)
                                valve_flag_next = 1'b0;
                            applied_speed_next = demand_speed_reg;
                            switch_phase_next  = fcfs_pkg::PHASE_ON;
                        end
                    end
                    out_valid_next  = 1'b1;
                    out_demand_next = demand_speed_reg;
                    out_drive_next  = drive_value_next;
                    out_valve_next  = valve_flag_next;
                    state_next      = fcfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcfs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign fan_demand    = out_demand_reg;
    assign fan_drive     = out_drive_reg;
    assign valve_request = out_valve_reg;

endmodule

/* rtl/fcfs_div.sv */
// ----------------------------------------------------------------------------
// Fan speed stager divider
// Restoring divider, one quotient bit per cycle, for the BLDC duty target.
// ----------------------------------------------------------------------------
module fcfs_div
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [fcfs_pkg::DIVIDEND_W-1:0]       dividend,
    input  logic [fcfs_pkg::DIVISOR_W-1:0]        divisor,
    output fcfs_pkg::fcfs_div_status_t            status,
    output logic [fcfs_pkg::DIVIDEND_W-1:0]       quotient
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [fcfs_pkg::DIV_CNT_W-1:0]      count_reg, count_next;
    logic [fcfs_pkg::DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [fcfs_pkg::DIVISOR_W-1:0]      dsr_reg, dsr_next;
    logic [fcfs_pkg::DIVIDEND_W-1:0]     quo_reg, quo_next;
    logic [fcfs_pkg::DIVISOR_W:0]        shifted;
    logic [fcfs_pkg::DIVISOR_W:0]        trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        shifted    = {rem_reg, quo_reg[fcfs_pkg::DIVIDEND_W-1]};
        trial      = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = fcfs_pkg::DIV_CNT_W'(fcfs_pkg::DIVIDEND_W);
            rem_next   = '0;
            dsr_next   = divisor;
            quo_next   = dividend;
        end
        else if (busy_reg)
        begin
            if (!trial[fcfs_pkg::DIVISOR_W])
            begin
                rem_next = trial[fcfs_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[fcfs_pkg::DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[fcfs_pkg::DIVISOR_W-1:0];
                quo_next = {quo_reg[fcfs_pkg::DIVIDEND_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == fcfs_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

/* rtl/fcfs_checker.sv */
// ----------------------------------------------------------------------------
// Fan speed stager port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "fancoil_fan_speed_stager_unit_defines.svh"

module fcfs_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [7:0]                          fan_demand,
    input  logic [7:0]                          fan_drive,
    input  logic                                valve_request
);

    `FCFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(fan_demand) && $stable(fan_drive) && $stable(valve_request),
        "result word changed while stalled")

    `FCFS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "input taken again while a pass is in progress")

    `FCFS_ASSERT_NEXT(a_no_back_to_back_out, out_valid && !out_stall, !out_valid,
        "result word appeared without a pass")

    `FCFS_ASSERT_NEXT(a_out_follows_pass, !out_valid && !in_stall && !(in_valid),
        !out_valid, "result word without an accepted input")

endmodule

bind fancoil_fan_speed_stager_unit fcfs_checker u_fcfs_checker (.*);

/* tb/fancoil_fan_speed_stager_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed stager unit test
// Sends control passes through the stager under random handshake gaps, a long
// output hold-off and a range of register settings. A scoreboard predicts
// each result word from its own copy of the stager state and checks it field
// by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [11:0] room_temp;
    logic [5:0]  setpoint;
    logic        regulator_on;
    logic        heating;
    logic        loop_tick;
    logic [31:0] now_ms;
} pass_word_t;

typedef struct packed {
    logic [7:0] fan_demand;
    logic [7:0] fan_drive;
    logic       valve_request;
} fan_word_t;

class fan_speed_scoreboard;
    logic        bldc_motor;
    logic [7:0]  low_band;
    logic [7:0]  middle_band;
    logic [7:0]  speed_threshold;
    logic        valve_follows_fan;
    logic [15:0] min_on_ms;

    logic [7:0]  demand;
    logic [7:0]  applied;
    logic [1:0]  phase;
    logic [31:0] hold_start;
    logic        valve;
    logic [7:0]  drive;

    fan_word_t   expected_words[$];
    int          mismatches;

    function new();
        bldc_motor        = fcfs_pkg::RST_MOTOR_KIND;
        low_band          = fcfs_pkg::RST_LOW_BAND;
        middle_band       = fcfs_pkg::RST_MIDDLE_BAND;
        speed_threshold   = fcfs_pkg::RST_SPEED_THRESHOLD;
        valve_follows_fan = fcfs_pkg::RST_VALVE_FOLLOWS;
        min_on_ms         = fcfs_pkg::RST_MIN_ON_MS;
        demand            = fcfs_pkg::SPEED_OFF;
        applied           = fcfs_pkg::SPEED_OFF;
        phase             = fcfs_pkg::PHASE_IDLE;
        hold_start        = '0;
        valve             = 1'b0;
        drive             = fcfs_pkg::SPEED_OFF;
        mismatches        = 0;
    endfunction

    function void set_register(logic [fcfs_pkg::CFG_IDX_W-1:0] index,
                               logic [fcfs_pkg::CFG_DATA_W-1:0] data);
        case (index)
            fcfs_pkg::CFG_MOTOR_KIND:      bldc_motor = data[0];
            fcfs_pkg::CFG_LOW_BAND:        low_band = data[7:0];
            fcfs_pkg::CFG_MIDDLE_BAND:     middle_band = data[7:0];
            fcfs_pkg::CFG_SPEED_THRESHOLD: speed_threshold = data[7:0];
            fcfs_pkg::CFG_VALVE_FOLLOWS:   valve_follows_fan = data[0];
            fcfs_pkg::CFG_MIN_ON_MS:       min_on_ms = data;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function void note_pass(pass_word_t w);
        int          t;
        int          sp;
        int          err;
        int          lo;
        int          mid;
        int          th;
        int          span;
        int          target;
        int          duty;
        logic [31:0] elapsed;
        t   = int'(w.room_temp);
        sp  = int'(w.setpoint) * int'(fcfs_pkg::SETPOINT_SCALE);
        lo  = int'(low_band);
        mid = int'(middle_band);
        th  = int'(speed_threshold);

        if (!w.regulator_on)
        begin
            phase   = fcfs_pkg::PHASE_IDLE;
            demand  = fcfs_pkg::SPEED_OFF;
            applied = fcfs_pkg::SPEED_OFF;
            drive   = fcfs_pkg::SPEED_OFF;
            valve   = 1'b0;
        end
        else if (bldc_motor)
        begin
            if (w.loop_tick)
            begin
                err = w.heating ? sp - t : t - sp;
                if (demand == fcfs_pkg::SPEED_OFF &&
                    err > int'(fcfs_pkg::BLDC_START_MARGIN))
                    demand = fcfs_pkg::SPEED_ONE;
                else if (err <= 0)
                    demand = fcfs_pkg::SPEED_OFF;
                else if (demand != fcfs_pkg::SPEED_OFF)
                begin
                    span = (th == 0) ? 1 : th;
                    if (err > th)
                        target = mid;
                    else
                        target = (err * int'(fcfs_pkg::PCT_SCALE)) / span;
                    duty = int'(demand);
                    if (duty < target)
                        duty = duty + 1;
                    else if (duty > target)
                        duty = duty - 1;
                    if (duty > mid)
                        duty = mid;
                    else if (duty < lo)
                        duty = lo;
                    demand = duty[7:0];
                end
            end
        end
        else if (w.heating)
        begin
            if (demand == fcfs_pkg::SPEED_OFF && t < sp - lo)
                demand = fcfs_pkg::SPEED_ONE;
            else if (demand == fcfs_pkg::SPEED_ONE && t < sp - mid)
                demand = fcfs_pkg::SPEED_TWO;
            else if (demand == fcfs_pkg::SPEED_ONE && t >= sp)
                demand = fcfs_pkg::SPEED_OFF;
            else if (demand == fcfs_pkg::SPEED_TWO && t < sp - mid - lo)
                demand = fcfs_pkg::SPEED_THREE;
            else if (demand == fcfs_pkg::SPEED_TWO && t >= sp - mid + th)
                demand = fcfs_pkg::SPEED_ONE;
            else if (demand == fcfs_pkg::SPEED_THREE && t >= sp - mid - lo + th)
                demand = fcfs_pkg::SPEED_TWO;
        end
        else
        begin
            if (demand == fcfs_pkg::SPEED_OFF && t > sp + lo)
                demand = fcfs_pkg::SPEED_ONE;
            else if (demand == fcfs_pkg::SPEED_ONE && t > sp + mid)
                demand = fcfs_pkg::SPEED_TWO;
            else if (demand == fcfs_pkg::SPEED_ONE && t <= sp)
                demand = fcfs_pkg::SPEED_OFF;
            else if (demand == fcfs_pkg::SPEED_ONE && t <= sp + th)
            begin
                if (!valve_follows_fan)
                    valve = 1'b0;
            end
            else if (demand == fcfs_pkg::SPEED_TWO && t > sp + mid + lo)
                demand = fcfs_pkg::SPEED_THREE;
            else if (demand == fcfs_pkg::SPEED_TWO && t <= sp + mid - th)
                demand = fcfs_pkg::SPEED_ONE;
            else if (demand == fcfs_pkg::SPEED_THREE && t <= sp + mid + lo - th)
                demand = fcfs_pkg::SPEED_TWO;
        end

        elapsed = w.now_ms - hold_start;
        if (demand != applied && elapsed >= {16'd0, min_on_ms})
        begin
            if (bldc_motor)
                drive = demand;
            if (phase > fcfs_pkg::PHASE_OFF)
                phase = fcfs_pkg::PHASE_IDLE;
            if (phase == fcfs_pkg::PHASE_IDLE)
            begin
                if (!bldc_motor)
                    drive = fcfs_pkg::SPEED_OFF;
                if (applied != fcfs_pkg::SPEED_OFF)
                    hold_start = w.now_ms;
                phase = fcfs_pkg::PHASE_OFF;
            end
            else
            begin
                if (!bldc_motor)
                    drive = (demand >= fcfs_pkg::SPEED_ONE &&
                             demand <= fcfs_pkg::SPEED_THREE) ? demand : fcfs_pkg::SPEED_OFF;
                if (demand != fcfs_pkg::SPEED_OFF)
                begin
                    valve      = 1'b1;
                    hold_start = w.now_ms;
                end
                else if (valve_follows_fan || !w.heating)
                    valve = 1'b0;
                applied = demand;
                phase   = fcfs_pkg::PHASE_ON;
            end
        end

        expected_words.push_back({demand, drive, valve});
    endfunction

    function void check_result(fan_word_t got);
        fan_word_t want;
        if (expected_words.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected word: demand %0d drive %0d valve %0d",
                         got.fan_demand, got.fan_drive, got.valve_request);
            mismatches++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.fan_demand !== want.fan_demand || got.fan_drive !== want.fan_drive ||
                got.valve_request !== want.valve_request)
            begin
                if (mismatches < 10)
                    $display({"word mismatch (expected/actual): ",
                              "demand %0d/%0d drive %0d/%0d valve %0d/%0d"},
                             want.fan_demand, got.fan_demand, want.fan_drive, got.fan_drive,
                             want.valve_request, got.valve_request);
                mismatches++;
            end
        end
    endfunction
endclass

module fancoil_fan_speed_stager_unit_test;

    localparam logic [fcfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LOW  = 3'd6;
    localparam logic [fcfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HIGH = 3'd7;
    localparam int PHASES           = 12;
    localparam int PASSES_PER_PHASE = 115;
    localparam int LONG_HOLD_CYCLES = 150;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [fcfs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fcfs_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [11:0]                     room_temp;
    logic [5:0]                      setpoint;
    logic                            regulator_on;
    logic                            heating;
    logic                            loop_tick;
    logic [31:0]                     now_ms;
    logic                            out_valid;
    logic                            out_stall;
    logic [7:0]                      fan_demand;
    logic [7:0]                      fan_drive;
    logic                            valve_request;

    logic                            sender_idles;
    logic                            receiver_idles;
    logic                            long_hold_due;
    logic [31:0]                     clock_ms;

    fan_speed_scoreboard tracker = new();

    fancoil_fan_speed_stager_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .room_temp     (room_temp),
        .setpoint      (setpoint),
        .regulator_on  (regulator_on),
        .heating       (heating),
        .loop_tick     (loop_tick),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fan_demand    (fan_demand),
        .fan_drive     (fan_drive),
        .valve_request (valve_request)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({fan_demand, fan_drive, valve_request});

    initial
    begin : receiver
        int   hold;
        logic long_hold_spent;
        out_stall       = 1'b0;
        long_hold_spent = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_due && !long_hold_spent)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_spent = 1'b1;
            end
            else
            begin
                hold = receiver_idles ? int'($urandom_range(0, 6)) : 0;
                if (hold != 0)
                begin
                    out_stall = 1'b1;
                    repeat (hold) @(negedge clk);
                end
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_pass(pass_word_t w);
        int gap;
        gap = sender_idles ? int'($urandom_range(0, 6)) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        room_temp    = w.room_temp;
        setpoint     = w.setpoint;
        regulator_on = w.regulator_on;
        heating      = w.heating;
        loop_tick    = w.loop_tick;
        now_ms       = w.now_ms;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_stall);
        tracker.note_pass(w);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(logic [fcfs_pkg::CFG_IDX_W-1:0] index,
                                  logic [fcfs_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        tracker.set_register(index, data);
    endtask

    // junk in the unused upper bits must be dropped by the block
    task automatic load_settings(logic bldc, logic [7:0] lo, logic [7:0] mid, logic [7:0] th,
                                 logic follows, logic [15:0] min_on);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 65535));
        write_register(fcfs_pkg::CFG_MOTOR_KIND, {junk[15:1], bldc});
        write_register(fcfs_pkg::CFG_LOW_BAND, {junk[15:8], lo});
        write_register(fcfs_pkg::CFG_MIDDLE_BAND, {junk[7:0], mid});
        write_register(fcfs_pkg::CFG_SPEED_THRESHOLD, {junk[11:4], th});
        write_register(fcfs_pkg::CFG_VALVE_FOLLOWS, {junk[14:0], follows});
        write_register(fcfs_pkg::CFG_MIN_ON_MS, min_on);
        write_register(CFG_SPARE_LOW, 16'($urandom_range(0, 65535)));
        write_register(CFG_SPARE_HIGH, 16'($urandom_range(0, 65535)));
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    initial
    begin : stimulus
        int          p;
        int          r;
        int          offset;
        int          span;
        int          stride;
        int          temp;
        logic [5:0]  setpt;
        logic        heat_mode;
        logic        bldc;
        logic        follows;
        logic [7:0]  lo;
        logic [7:0]  mid;
        logic [7:0]  th;
        logic [15:0] min_on;
        pass_word_t  w;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = fcfs_pkg::CFG_MOTOR_KIND;
        cfg_data       = '0;
        in_valid       = 1'b0;
        room_temp      = '0;
        setpoint       = '0;
        regulator_on   = 1'b0;
        heating        = 1'b0;
        loop_tick      = 1'b0;
        now_ms         = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        long_hold_due  = 1'b0;
        clock_ms       = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // regulator off, then cooling up through the steps and back down
        send_pass({12'd4095, 6'd63, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF});
        send_pass({12'd260, 6'd20, 1'b1, 1'b0, 1'b0, 32'd10000});
        send_pass({12'd260, 6'd20, 1'b1, 1'b0, 1'b0, 32'd13000});
        send_pass({12'd270, 6'd20, 1'b1, 1'b0, 1'b0, 32'd16000});
        send_pass({12'd270, 6'd20, 1'b1, 1'b0, 1'b0, 32'd19000});
        send_pass({12'd200, 6'd20, 1'b1, 1'b0, 1'b0, 32'd22000});
        send_pass({12'd200, 6'd20, 1'b1, 1'b0, 1'b0, 32'd25000});
        send_pass({12'd202, 6'd20, 1'b1, 1'b0, 1'b0, 32'd28000});
        send_pass({12'd190, 6'd20, 1'b1, 1'b0, 1'b0, 32'd31000});
        send_pass({12'd190, 6'd20, 1'b1, 1'b0, 1'b0, 32'd34000});
        // heating at the extremes, then a wrap of the millisecond count
        send_pass({12'd0, 6'd63, 1'b1, 1'b1, 1'b0, 32'd40000});
        send_pass({12'd0, 6'd63, 1'b1, 1'b1, 1'b0, 32'd43000});
        send_pass({12'd0, 6'd63, 1'b1, 1'b1, 1'b0, 32'd46000});
        send_pass({12'd630, 6'd63, 1'b1, 1'b1, 1'b0, 32'hFFFF_FF00});
        send_pass({12'd630, 6'd63, 1'b1, 1'b1, 1'b0, 32'h0000_0100});
        send_pass({12'd630, 6'd63, 1'b1, 1'b1, 1'b0, 32'h0000_2000});

        settle();
        load_settings(1'b1, 8'd20, 8'd200, 8'd0, 1'b1, 16'd0);
        send_pass({12'd100, 6'd30, 1'b1, 1'b1, 1'b0, 32'd0});
        send_pass({12'd100, 6'd30, 1'b1, 1'b1, 1'b1, 32'd5});
        send_pass({12'd295, 6'd30, 1'b1, 1'b1, 1'b1, 32'd6});
        send_pass({12'd300, 6'd30, 1'b1, 1'b1, 1'b1, 32'd7});
        send_pass({12'd100, 6'd30, 1'b1, 1'b1, 1'b1, 32'd8});
        send_pass({12'd295, 6'd30, 1'b1, 1'b1, 1'b1, 32'd9});

        // stepped motor left with a duty above the top step
        settle();
        load_settings(1'b0, 8'd20, 8'd200, 8'd0, 1'b1, 16'd0);
        send_pass({12'd250, 6'd30, 1'b1, 1'b0, 1'b0, 32'd10});
        send_pass({12'd250, 6'd30, 1'b1, 1'b0, 1'b0, 32'd11});

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: {bldc, lo, mid, th, follows, min_on} =
                       {1'b0, 8'd0, 8'd0, 8'd0, 1'b1, 16'd0};
                1: {bldc, lo, mid, th, follows, min_on} =
                       {1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 16'hFFFF};
                2: {bldc, lo, mid, th, follows, min_on} =
                       {1'b1, 8'd0, 8'd255, 8'd1, 1'b0, 16'd0};
                3: {bldc, lo, mid, th, follows, min_on} =
                       {1'b1, 8'd255, 8'd0, 8'd0, 1'b1, 16'hFFFF};
                4: {bldc, lo, mid, th, follows, min_on} =
                       {1'b0, 8'd5, 8'd10, 8'd3, 1'b0, 16'd3000};
                5: {bldc, lo, mid, th, follows, min_on} =
                       {1'b1, 8'd10, 8'd120, 8'd255, 1'b1, 16'd50};
                default:
                begin
                    bldc    = 1'($urandom_range(0, 1));
                    lo      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 40));
                    mid     = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 60));
                    th      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 20));
                    follows = 1'($urandom_range(0, 1));
                    min_on  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                          : 16'($urandom_range(0, 3000));
                end
            endcase
            load_settings(bldc, lo, mid, th, follows, min_on);

            sender_idles   = (p % 4 != 3);
            receiver_idles = (p % 3 != 2);
            long_hold_due  = (p == 6);
            heat_mode      = 1'($urandom_range(0, 1));
            setpt          = 6'($urandom_range(5, 40));
            offset         = 0;
            clock_ms       = $urandom;
            span           = int'(lo) + int'(mid) + int'(th) + 20;
            stride         = span / 12 + 2;

            repeat (PASSES_PER_PHASE)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 2)
                    setpt = 6'($urandom_range(0, 63));
                if (r == 99)
                    heat_mode = ~heat_mode;
                if (r < 8)
                    offset = int'($urandom_range(0, 2 * span)) - span;
                else
                    offset = offset + int'($urandom_range(0, 2 * stride)) - stride;
                if (offset > span)
                    offset = span;
                if (offset < -span)
                    offset = -span;
                temp = int'(setpt) * int'(fcfs_pkg::SETPOINT_SCALE) + offset;
                if (temp < 0)
                    temp = 0;
                if (temp > 4095)
                    temp = 4095;
                if (r >= 12)
                    clock_ms = clock_ms + $urandom_range(0, int'(min_on) * 3 / 4 + 20);

                w.room_temp    = 12'(temp);
                w.setpoint     = setpt;
                w.regulator_on = ($urandom_range(0, 39) != 0);
                w.heating      = (r == 50) ? ~heat_mode : heat_mode;
                w.loop_tick    = ($urandom_range(0, 3) != 0);
                w.now_ms       = clock_ms;
                if (r < 4)
                begin
                    w.room_temp    = 12'($urandom_range(0, 4095));
                    w.setpoint     = 6'($urandom_range(0, 63));
                    w.regulator_on = 1'($urandom_range(0, 1));
                    w.heating      = 1'($urandom_range(0, 1));
                    w.loop_tick    = 1'($urandom_range(0, 1));
                    w.now_ms       = $urandom;
                end
                send_pass(w);
            end
        end

        settle();
        repeat (30) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* fancoil_fan_speed_stager_unit.f */
+incdir+rtl
rtl/fcfs_pkg.sv
rtl/fcfs_div.sv
rtl/fancoil_fan_speed_stager_unit.sv
rtl/fcfs_checker.sv
tb/fancoil_fan_speed_stager_unit_test.sv
